@@ rtl/pte_pkg.sv @@
package pte_pkg;

	localparam int ID_BITS = 16;
	localparam int OUT_TIME_BITS = 32;
	localparam logic [31:0] TPU_RESET = 32'd1000;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SUB  = 1'b1;

	localparam logic RES_FIRE   = 1'b0;
	localparam logic RES_STATUS = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_FLUSH,
		S_STAT
	} pte_state_t;

	typedef struct packed {
		logic tick_start;
		logic sub_start;
		logic rd_issue;
		logic cmp_step;
		logic end_scan;
		logic flush;
		logic out_status;
	} pte_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic match;
		logic pend_valid;
		logic out_free;
	} pte_sts_t;

endpackage

@@ rtl/prescaled_timer_event_list.sv @@
// prescaled timer with a bounded table of pending events
// input channel (in_valid/in_stall): kind 0 is a raw tick, kind 1 subscribes
// event_id to fire at event_time; a word is taken when in_valid is high and
// in_stall is low
// output channel (out_valid/out_stall): fired events and subscription status,
// last marks the final word caused by one input; a tick that fires nothing
// gives no word
// cfg channel: cfg_data writes ticks_per_unit, always ready, reset value 1000
// subscribe: the status word is loaded in S_STAT once the output register is free
// tick: one ram read and one compare per pending slot (S_READ, S_CMP), then
// S_FLUSH; the table ram has one read port and one write port
// one input is worked on at a time; in_stall is high while it runs
// a stalled receiver holds the output register and the scan waits on it
// reset clears the counters and empties the table; no clearing pass
module prescaled_timer_event_list import pte_pkg::*; #(
	parameter int EVENT_SLOTS = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic [31:0]              event_time,
	input  logic [ID_BITS-1:0]       event_id,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     result_kind,
	output logic [ID_BITS-1:0]       fired_id,
	output logic [OUT_TIME_BITS-1:0] fire_time,
	output logic                     status,
	output logic                     last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [31:0]              cfg_data
);

	pte_cmd_t cmd;
	pte_sts_t sts;

	assign cfg_ready = 1'b1;

	pte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	pte_dpath #(
		.EVENT_SLOTS (EVENT_SLOTS),
		.TIME_BITS   (TIME_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.event_time  (event_time),
		.event_id    (event_id),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.result_kind (result_kind),
		.fired_id    (fired_id),
		.fire_time   (fire_time),
		.status      (status),
		.last        (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after taking a word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_step && sts.match && sts.pend_valid |-> sts.out_free)
		else $error("fire word loaded over a waiting word");

	a_status_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_status || cmd.flush |-> sts.out_free)
		else $error("final word loaded over a waiting word");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.tick_start, cmd.sub_start, cmd.rd_issue, cmd.cmp_step,
			cmd.end_scan, cmd.flush, cmd.out_status}))
		else $error("more than one command at once");

endmodule

@@ rtl/pte_ram.sv @@
module pte_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/pte_ctrl.sv @@
module pte_ctrl import pte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     kind,
	input  pte_sts_t sts,
	output pte_cmd_t cmd
);

	pte_state_t state_q, state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (kind == KIND_SUB) ? S_STAT : S_READ;
				end
			end
			S_READ: begin
				state_d = sts.scan_done ? S_FLUSH : S_CMP;
			end
			S_CMP: begin
				if (!(sts.match && sts.pend_valid && !sts.out_free)) begin
					state_d = S_READ;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.tick_start = accept && (kind == KIND_TICK);
				cmd.sub_start  = accept && (kind == KIND_SUB);
			end
			S_READ: begin
				cmd.end_scan = sts.scan_done;
				cmd.rd_issue = !sts.scan_done;
			end
			S_CMP: begin
				cmd.cmp_step = !(sts.match && sts.pend_valid && !sts.out_free);
			end
			S_FLUSH: begin
				cmd.flush = sts.pend_valid && sts.out_free;
			end
			S_STAT: begin
				cmd.out_status = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

@@ rtl/pte_dpath.sv @@
module pte_dpath import pte_pkg::*; #(
	parameter int EVENT_SLOTS = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pte_cmd_t                 cmd,
	output pte_sts_t                 sts,
	input  logic [31:0]              event_time,
	input  logic [ID_BITS-1:0]       event_id,
	input  logic                     cfg_valid,
	input  logic [31:0]              cfg_data,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic                     result_kind,
	output logic [ID_BITS-1:0]       fired_id,
	output logic [OUT_TIME_BITS-1:0] fire_time,
	output logic                     status,
	output logic                     last
);

	localparam int IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int CW = $clog2(EVENT_SLOTS + 1);
	localparam int EW = TIME_BITS + ID_BITS;

	logic [31:0]          tpu_q, prescale_q, prescale_inc;
	logic [TIME_BITS-1:0] time_q;
	logic [CW-1:0]        count_q, scan_q, keep_q;
	logic                 pend_valid_q, sub_st_q, out_valid_q;
	logic [ID_BITS-1:0]   pend_id_q;
	logic                 full, tick_hit, match, load_mid;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	assign prescale_inc = prescale_q + 32'd1;
	assign tick_hit     = (prescale_inc == tpu_q);
	assign full         = !(count_q < CW'(EVENT_SLOTS));
	assign match        = (ram_rdata[EW-1:ID_BITS] == time_q);
	assign load_mid     = cmd.cmp_step && match && pend_valid_q;

	assign ram_we    = (cmd.sub_start && !full) || (cmd.cmp_step && !match);
	assign ram_waddr = cmd.sub_start ? count_q[IW-1:0] : keep_q[IW-1:0];
	assign ram_wdata = cmd.sub_start ? {TIME_BITS'(event_time), event_id} : ram_rdata;

	pte_ram #(
		.WIDTH (EW),
		.DEPTH (EVENT_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_issue),
		.raddr (scan_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q        <= TPU_RESET;
			prescale_q   <= '0;
			time_q       <= '0;
			count_q      <= '0;
			scan_q       <= '0;
			keep_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tpu_q <= cfg_data;
			end
			if (cmd.tick_start) begin
				scan_q       <= '0;
				keep_q       <= '0;
				pend_valid_q <= 1'b0;
				if (tick_hit) begin
					prescale_q <= prescale_inc - tpu_q;
					time_q     <= time_q + TIME_BITS'(1);
				end else begin
					prescale_q <= prescale_inc;
				end
			end
			if (cmd.sub_start && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.cmp_step) begin
				scan_q <= scan_q + CW'(1);
				if (match) begin
					pend_valid_q <= 1'b1;
				end else begin
					keep_q <= keep_q + CW'(1);
				end
			end
			if (cmd.end_scan) begin
				count_q <= keep_q;
			end
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (load_mid || cmd.flush || cmd.out_status) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sub_start) begin
			sub_st_q <= full ? ST_FULL : ST_OK;
		end
		if (cmd.cmp_step && match) begin
			pend_id_q <= ram_rdata[ID_BITS-1:0];
		end
		if (load_mid || cmd.flush) begin
			result_kind <= RES_FIRE;
			fired_id    <= pend_id_q;
			fire_time   <= OUT_TIME_BITS'(time_q);
			status      <= ST_OK;
			last        <= cmd.flush;
		end else if (cmd.out_status) begin
			result_kind <= RES_STATUS;
			fired_id    <= '0;
			fire_time   <= '0;
			status      <= sub_st_q;
			last        <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.scan_done  = (scan_q == count_q);
	assign sts.match      = match;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

@@ test/tb_prescaled_timer_event_list.sv @@
module tb_prescaled_timer_event_list import pte_pkg::*; ;

	localparam int SLOTS = 16;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 48;

	typedef struct packed {
		logic                     r_kind;
		logic [ID_BITS-1:0]       r_id;
		logic [OUT_TIME_BITS-1:0] r_time;
		logic                     r_status;
		logic                     r_last;
	} timer_word_t;

	class event_list_scoreboard;
		logic [31:0] rate = TPU_RESET;
		logic [31:0] prescale = '0;
		logic [31:0] now = '0;
		logic [31:0] slot_time[SLOTS];
		logic [15:0] slot_id[SLOTS];
		int unsigned used = 0;
		timer_word_t fired_words[$];
		int unsigned failures = 0;

		function void set_rate(logic [31:0] v);
			rate = v;
		endfunction

		function int unsigned pending();
			return fired_words.size();
		endfunction

		// entries that the running time will not reach for a long while
		function int unsigned stuck_count();
			int unsigned n;
			n = 0;
			for (int i = 0; i < used; i++) begin
				if (slot_time[i] - now > 32'd1000) n++;
			end
			return n;
		endfunction

		function void note_input(logic k, logic [31:0] t, logic [15:0] id);
			int unsigned keep;
			int last_at;
			timer_word_t w;
			if (k == KIND_SUB) begin
				w = '{RES_STATUS, '0, '0, ST_FULL, 1'b1};
				if (used < SLOTS) begin
					slot_time[used] = t;
					slot_id[used] = id;
					used++;
					w.r_status = ST_OK;
				end
				fired_words.push_back(w);
				return;
			end
			prescale = prescale + 32'd1;
			if (prescale == rate) begin
				now = now + 32'd1;
				prescale = prescale - rate;
			end
			keep = 0;
			last_at = -1;
			for (int i = 0; i < used; i++) begin
				if (slot_time[i] == now) begin
					fired_words.push_back('{RES_FIRE, slot_id[i], now, ST_OK, 1'b0});
					last_at = fired_words.size() - 1;
				end else begin
					slot_time[keep] = slot_time[i];
					slot_id[keep] = slot_id[i];
					keep++;
				end
			end
			used = keep;
			if (last_at >= 0) fired_words[last_at].r_last = 1'b1;
		endfunction

		function void check_word(timer_word_t got);
			timer_word_t want;
			if (fired_words.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected word: kind=%0d id=%h time=%h status=%0d last=%0d",
						got.r_kind, got.r_id, got.r_time, got.r_status, got.r_last);
				return;
			end
			want = fired_words.pop_front();
			if (got.r_kind !== want.r_kind || got.r_id !== want.r_id ||
					got.r_time !== want.r_time || got.r_status !== want.r_status ||
					got.r_last !== want.r_last) begin
				failures++;
				if (failures <= 10)
					$display("word mismatch: expected kind=%0d id=%h time=%h status=%0d last=%0d,",
						want.r_kind, want.r_id, want.r_time, want.r_status, want.r_last,
						" got kind=%0d id=%h time=%h status=%0d last=%0d",
						got.r_kind, got.r_id, got.r_time, got.r_status, got.r_last);
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     kind = KIND_TICK;
	logic [31:0]              event_time = '0;
	logic [ID_BITS-1:0]       event_id = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     result_kind;
	logic [ID_BITS-1:0]       fired_id;
	logic [OUT_TIME_BITS-1:0] fire_time;
	logic                     status;
	logic                     last;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [31:0]              cfg_data = '0;

	event_list_scoreboard sb = new;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	bit calm = 1'b0;

	prescaled_timer_event_list dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(1, 13);
			out_stall <= 1'b1;
		end else begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word({result_kind, fired_id, fire_time, status, last});
	end

	task automatic send(input logic k, input logic [31:0] t, input logic [15:0] id);
		if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		event_time <= t;
		event_id <= id;
		do @(posedge clk); while (in_stall);
		sb.note_input(k, t, id);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_rate(v);
	endtask

	// bring the prescaler back under the new rate so that time keeps moving
	task automatic realign(input logic [31:0] v);
		if (sb.prescale >= v) begin
			configure(sb.prescale + 32'd1);
			send(KIND_TICK, $urandom, 16'($urandom));
		end
		configure(v);
	endtask

	task automatic random_items(input int n, input int sub_pct);
		logic [31:0] t;
		bit frozen;
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0 && !calm) begin
				gap_pct = $urandom_range(0, 2) * 15;
				stall_pct = $urandom_range(0, 2) * 15;
			end
			frozen = (sb.rate <= sb.prescale) || (sb.rate - sb.prescale > 32'd64);
			if ($urandom_range(0, 99) < sub_pct) begin
				if ($urandom_range(0, 99) < 8 && sb.stuck_count() < 4)
					t = $urandom_range(0, 1) ? $urandom : sb.now - $urandom_range(1, 40);
				else if (frozen)
					t = sb.now;
				else
					t = sb.now + $urandom_range(1, 8);
				send(KIND_SUB, t, 16'($urandom));
			end else begin
				send(KIND_TICK, $urandom, 16'($urandom));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the table with events due now, overflow it, then fire all at once
		for (int i = 0; i < SLOTS; i++)
			send(KIND_SUB, 32'd0,
				i == 0 ? 16'h0000 : (i == SLOTS - 1 ? 16'hffff : 16'($urandom)));
		send(KIND_SUB, 32'd0, 16'($urandom));
		send(KIND_TICK, $urandom, 16'($urandom));
		send(KIND_TICK, $urandom, 16'($urandom));
		send(KIND_SUB, 32'hffffffff, 16'hffff);

		realign(32'd1);
		send(KIND_SUB, sb.now + 32'd1, 16'($urandom));
		send(KIND_SUB, sb.now + 32'd1, 16'($urandom));
		send(KIND_SUB, sb.now + 32'd2, 16'($urandom));
		send(KIND_TICK, $urandom, 16'($urandom));
		send(KIND_TICK, $urandom, 16'($urandom));

		random_items(60, 60);
		realign(32'd3);
		random_items(50, 50);
		configure(32'hffffffff);
		random_items(30, 55);
		// rate dropped below the running count: time stands still
		configure(32'd2);
		random_items(25, 50);
		configure(32'd0);
		random_items(20, 50);
		realign($urandom_range(2, 6));
		random_items(60, 45);
		realign(32'd1);
		random_items(50, 65);

		realign(32'd2);
		calm = 1'b1;
		gap_pct = 0;
		stall_pct = 0;
		random_items(60, 55);
		wait_idle();

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
